[hdl/sha256_pkg.sv]
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int LenStart   = 56;

    typedef logic [31:0] word_t;

    // Command handed from the front end to the core through the queue.
    typedef struct packed {
        logic       has_byte;
        logic       end_of_message;
        logic [7:0] data_byte;
    } cmd_t;

    localparam logic [255:0] HashInit = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        begin
            unique case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic word_t rotr(input word_t v, input int n);
        begin
            return (v >> n) | (v << (32 - n));
        end
    endfunction

endpackage

[hdl/sha256_byte_stream_hasher_unit.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake        | Payload
// input    | in        | in_valid/ready   | data_byte, has_byte, end_of_message
// output   | out       | out_valid/ready  | digest_word, word_index, last_word
//
// The core takes a byte item while idle; every 64th byte starts a block of
// the 64 one-round-per-cycle compression steps plus a fold into the hash.
// End of message runs one more block, plus a pad block when the length does not fit,
// then eight digest items, one per cycle while out_ready holds.
// Reset loads the initial hash and clears the fill count and length.
// A two-item queue parts the front from the core; a stalled output holds the core.
module sha256_byte_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::cmd_t cmd;
    logic             cmd_valid, cmd_ready;

    sha256_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    sha256_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

[hdl/sha256_front.sv]
`timescale 1ns / 1ps

module sha256_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_message,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output sha256_pkg::cmd_t    cmd
);

    // Two-entry queue; drop items that carry neither a byte nor an end mark.
    sha256_pkg::cmd_t q_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop, useful;

    assign useful    = has_byte | end_of_message;
    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid & in_ready & useful;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid & cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{has_byte: has_byte, end_of_message: end_of_message,
                                   data_byte: data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[hdl/sha256_core.sv]
`timescale 1ns / 1ps

module sha256_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sha256_pkg::cmd_t    cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_FOLD, S_PAD, S_EMIT
    } state_t;

    state_t        state_reg;
    logic [255:0]  hash_reg;
    logic [255:0]  work_reg;
    logic [511:0]  blk_reg;      // 16 words, word 0 in the top bits; rolls as schedule
    logic [5:0]    fill_reg;
    logic [63:0]   len_reg;
    logic [5:0]    round_reg;
    logic          final_reg;    // this block closes the message
    logic          pend_reg;     // pad block still to run after this one
    logic [2:0]    idx_reg;

    sha256_pkg::word_t a, b, c, d, e, f, g, h, w, x15, x2, x7, x16;
    sha256_pkg::word_t s0w, s1w, t1, t2, wnext;

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = work_reg;
        w   = blk_reg[511 -: 32];
        x16 = w;
        x15 = blk_reg[479 -: 32];
        x7  = blk_reg[223 -: 32];
        x2  = blk_reg[63 -: 32];
        s0w = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
        s1w = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
        wnext = x16 + s0w + x7 + s1w;
        t1 = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
               + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(round_reg) + w;
        t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
    end

    assign cmd_ready   = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign digest_word = hash_reg[255 - 32 * idx_reg -: 32];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [511:0] nb;
        logic [5:0]   nf;
        logic [63:0]  nl;
        logic [255:0] hs;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hash_reg  <= sha256_pkg::HashInit;
            fill_reg  <= '0;
            len_reg   <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        nb = blk_reg;
                        nf = fill_reg;
                        nl = len_reg;
                        if (cmd.has_byte)
                        begin
                            nb[511 - 8 * nf -: 8] = cmd.data_byte;
                            nl = nl + 64'd8;
                        end
                        if (cmd.end_of_message)
                        begin
                            if (cmd.has_byte && nf == 6'd63)
                            begin
                                // Byte fills the block: run it, pad in a fresh block.
                                pend_reg  <= 1'b1;
                                final_reg <= 1'b0;
                                work_reg  <= hash_reg;
                                round_reg <= '0;
                                state_reg <= S_ROUND;
                                nf = '0;
                            end
                            else
                            begin
                                if (cmd.has_byte)
                                    nf = nf + 6'd1;
                                nb[511 - 8 * nf -: 8] = 8'h80;
                                for (int i = 0; i < 64; i++)
                                    if (i > nf)
                                        nb[511 - 8 * i -: 8] = 8'h00;
                                if (nf < 6'(sha256_pkg::LenStart))
                                begin
                                    nb[63:0]  = nl;
                                    final_reg <= 1'b1;
                                    pend_reg  <= 1'b0;
                                end
                                else
                                begin
                                    final_reg <= 1'b0;
                                    pend_reg  <= 1'b1;
                                end
                                work_reg  <= hash_reg;
                                round_reg <= '0;
                                state_reg <= S_ROUND;
                                nf = '0;
                            end
                        end
                        else if (cmd.has_byte)
                        begin
                            if (nf == 6'd63)
                            begin
                                final_reg <= 1'b0;
                                pend_reg  <= 1'b0;
                                work_reg  <= hash_reg;
                                round_reg <= '0;
                                state_reg <= S_ROUND;
                            end
                            nf = nf + 6'd1;
                        end
                        blk_reg  <= nb;
                        fill_reg <= nf;
                        len_reg  <= nl;
                    end
                end
                S_ROUND:
                begin
                    work_reg  <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    blk_reg   <= {blk_reg[479:0], wnext};
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        hs[255 - 32 * i -: 32] = hash_reg[255 - 32 * i -: 32]
                                                 + work_reg[255 - 32 * i -: 32];
                    hash_reg <= hs;
                    if (final_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (pend_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                end
                S_PAD:
                begin
                    // Extra block: 0x80 only if it did not fit before, then length.
                    nb = '0;
                    if (len_reg[8:3] == 6'd0)
                        nb[511 -: 8] = 8'h80;
                    nb[63:0]  = len_reg;
                    blk_reg   <= nb;
                    work_reg  <= hash_reg;
                    round_reg <= '0;
                    final_reg <= 1'b1;
                    pend_reg  <= 1'b0;
                    state_reg <= S_ROUND;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            hash_reg  <= sha256_pkg::HashInit;
                            len_reg   <= '0;
                            fill_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[test/tb_sha256_byte_stream_hasher_unit.sv]
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher_unit;

    localparam int CycleLimit = 2000000;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    // One row of the directed table; a typed digest word 0 means "take the predictor".
    typedef struct {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        end_of_message;
        logic        typed;
        logic [31:0] word0;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // Predictor state: running hash, partial block, fill count and bit length.
    logic [31:0] run_hash [8];
    logic [7:0]  blk_bytes [64];
    int          blk_fill;
    logic [63:0] bit_len;

    digest_item_t pending_digests [$];
    stim_row_t    dir_rows [$];
    int           error_count;
    int           cycle_count;
    logic         stim_done;

    sha256_byte_stream_hasher_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] rot_right(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sha_k(input int t);
        logic [31:0] k_tab [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k_tab[t];
    endfunction

    // Run the 64 rounds over the held block and fold into the running hash.
    task automatic compress_held_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = rot_right(w[t-15], 7) ^ rot_right(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rot_right(w[t-2], 17) ^ rot_right(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {run_hash[0], run_hash[1], run_hash[2], run_hash[3],
                                    run_hash[4], run_hash[5], run_hash[6], run_hash[7]};
        for (int t = 0; t < 64; t++)
        begin
            s1 = rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25);
            t1 = h + s1 + ((e & f) ^ (~e & g)) + sha_k(t) + w[t];
            s0 = rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22);
            t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
        run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            run_hash[i] = sha256_pkg::HashInit[255 - 32*i -: 32];
        blk_fill = 0;
        bit_len  = '0;
    endtask

    // Advance the predictor by one accepted item; queue digests on end of message.
    task automatic predict_digest(input logic [7:0] b, input logic hb, input logic eom);
        digest_item_t di;
        if (hb)
        begin
            blk_bytes[blk_fill] = b;
            blk_fill++;
            bit_len += 64'd8;
            if (blk_fill == 64)
            begin
                compress_held_block();
                blk_fill = 0;
            end
        end
        if (eom)
        begin
            blk_bytes[blk_fill] = 8'h80;
            blk_fill++;
            if (blk_fill > 56)
            begin
                while (blk_fill < 64)
                begin
                    blk_bytes[blk_fill] = 8'h00;
                    blk_fill++;
                end
                compress_held_block();
                blk_fill = 0;
            end
            while (blk_fill < 56)
            begin
                blk_bytes[blk_fill] = 8'h00;
                blk_fill++;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[56+i] = bit_len[63 - 8*i -: 8];
            compress_held_block();
            for (int i = 0; i < 8; i++)
            begin
                di.digest_word = run_hash[i];
                di.word_index  = 3'(i);
                di.last_word   = (i == 7);
                pending_digests.push_back(di);
            end
            restart_hash();
        end
    endtask

    // Drop valid only across a gap; back-to-back items keep it high.
    task automatic send_item(input logic [7:0] b, input logic hb, input logic eom);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        has_byte       <= hb;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_digest(b, hb, eom);
    endtask

    function automatic stim_row_t mk_row(input logic [7:0] b, input logic hb,
                                         input logic eom, input logic [31:0] w0);
        stim_row_t r;
        r.data_byte = b; r.has_byte = hb; r.end_of_message = eom;
        r.typed = (w0 != 32'h0); r.word0 = w0;
        return r;
    endfunction

    // Sender: directed table, then random messages.
    initial
    begin
        int msg_len;
        int first_idx;
        error_count    = 0;
        stim_done      = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        has_byte       = 1'b0;
        end_of_message = 1'b0;
        rst_n          = 1'b0;
        restart_hash();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, end without a byte.
        dir_rows.push_back(mk_row(8'h00, 1'b0, 1'b1, 32'he3b0c442));
        // No flags: ignored item.
        dir_rows.push_back(mk_row(8'hff, 1'b0, 1'b0, 32'h0));
        // "abc", last byte carried with the end flag.
        dir_rows.push_back(mk_row(8'h61, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(mk_row(8'h62, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(mk_row(8'h63, 1'b1, 1'b1, 32'hba7816bf));
        // Extremes and alternating patterns of the byte value.
        dir_rows.push_back(mk_row(8'hff, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(mk_row(8'h00, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(mk_row(8'haa, 1'b1, 1'b0, 32'h0));
        dir_rows.push_back(mk_row(8'h55, 1'b1, 1'b1, 32'h0));
        dir_rows.push_back(mk_row(8'h00, 1'b1, 1'b1, 32'h0));
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].data_byte, dir_rows[i].has_byte,
                      dir_rows[i].end_of_message);
            // The eight digests of a closing row sit at the back of the queue.
            first_idx = pending_digests.size() - 8;
            if (dir_rows[i].typed && pending_digests[first_idx].digest_word
                != dir_rows[i].word0)
            begin
                $error("digest_word expected %h actual %h", dir_rows[i].word0,
                       pending_digests[first_idx].digest_word);
                error_count++;
            end
        end

        // Lengths around the padding boundaries, then short random messages.
        for (int m = 0; m < 12; m++)
        begin
            case (m)
                0: msg_len = 55;
                1: msg_len = 56;
                2: msg_len = 63;
                3: msg_len = 64;
                default: msg_len = $urandom_range(0, 3);
            endcase
            for (int j = 0; j < msg_len; j++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 1))
                send_item(8'($urandom), 1'b1, 1'b1);
            else
                send_item(8'($urandom), 1'b0, 1'b1);
        end
        in_valid  <= 1'b0;
        stim_done <= 1'b1;
    end

    // Receiver: random stalls, one long hold-off early on.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        repeat (600) @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each accepted digest item with the oldest expectation.
    always @(posedge clk)
    begin
        digest_item_t ex;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digests.size() == 0)
            begin
                $error("unexpected digest item %h", digest_word);
                error_count++;
            end
            else
            begin
                ex = pending_digests.pop_front();
                if (digest_word !== ex.digest_word)
                begin
                    $error("digest_word expected %h actual %h", ex.digest_word, digest_word);
                    error_count++;
                end
                if (word_index !== ex.word_index)
                begin
                    $error("word_index expected %0d actual %0d", ex.word_index, word_index);
                    error_count++;
                end
                if (last_word !== ex.last_word)
                begin
                    $error("last_word expected %0d actual %0d", ex.last_word, last_word);
                    error_count++;
                end
            end
        end
    end

    // Finish once drained, or on the cycle limit.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (stim_done && pending_digests.size() == 0)
            begin
                repeat (300) @(posedge clk);
                if (error_count == 0 && pending_digests.size() == 0)
                    $display("RESULT: OK");
                else
                    $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
